>>> rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked outside reset
`define PRBM_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("assertion failed");

// property checked at every edge, reset included
`define PRBM_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

>>> rtl/prbm_pkg.sv
// package: widths, register indexes, command and status types, distance functions
package prbm_pkg;
    localparam int CW      = 24;
    localparam int WW      = 6;
    localparam int SLOT_W  = CW + WW;
    localparam int THR_W   = 10;
    localparam int DIST_W  = 10;
    localparam int NUM_W   = 14;
    localparam int DIV_REM_W = 7;
    localparam int IDX_W   = 16;
    localparam int RND_W   = 16;
    localparam int OUT_W   = 8;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 10;
    localparam int MOD_STEPS  = 1;
    localparam int DIV_STEPS  = NUM_W;
    localparam int RECIP3     = 683;
    localparam int RECIP3_SH  = 11;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT     = CFG_IDX_W'(1);

    localparam logic [THR_W-1:0] THRESHOLD_RST = THR_W'(30);
    localparam logic [WW-1:0]    LIMIT_RST     = WW'(50);

    typedef enum logic [1:0] {
        ACT_HIT  = 2'b00,
        ACT_INS  = 2'b01,
        ACT_REPL = 2'b10,
        ACT_NONE = 2'b11
    } act_t;

    typedef struct packed {
        logic clr;
        logic latch;
        logic mod_step;
        logic rd;
        logic eval;
        logic plan;
        logic div_step;
        logic wr;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic clr_done;
        logic out_free;
    } sts_t;

    function automatic logic [8:0] abs8(input logic [7:0] a, input logic [7:0] b);
        return (a > b) ? 9'(a - b) : 9'(b - a);
    endfunction

    function automatic logic [DIST_W-1:0] manhattan(input logic [CW-1:0] p,
                                                    input logic [CW-1:0] q);
        return DIST_W'(abs8(p[23:16], q[23:16])) + DIST_W'(abs8(p[15:8], q[15:8]))
             + DIST_W'(abs8(p[7:0], q[7:0]));
    endfunction
endpackage

>>> rtl/prbm_ram.sv
// generic single-port-write ram with registered read
module prbm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

>>> rtl/prbm_ctrl.sv
// sequencer: clearing pass, then one pixel at a time through the datapath
module prbm_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  prbm_pkg::sts_t  sts,
    output prbm_pkg::cmd_t  cmd
);
    import prbm_pkg::*;

    typedef enum logic [8:0] {
        S_CLR   = 9'b000000001,
        S_IDLE  = 9'b000000010,
        S_MOD   = 9'b000000100,
        S_READ  = 9'b000001000,
        S_EVAL  = 9'b000010000,
        S_PLAN  = 9'b000100000,
        S_DIV   = 9'b001000000,
        S_WRITE = 9'b010000000,
        S_OUT   = 9'b100000000
    } state_t;

    state_t     state_reg, state_next;
    logic [3:0] step_reg, step_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLR;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_CLR: begin
                cmd.clr = ~sts.clr_done;
                if (sts.clr_done) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.latch  = 1'b1;
                    step_next  = '0;
                    state_next = S_MOD;
                end
            end
            S_MOD: begin
                cmd.mod_step = 1'b1;
                step_next    = step_reg + 4'd1;
                if (step_reg == 4'(MOD_STEPS - 1)) begin
                    state_next = S_READ;
                end
            end
            S_READ: begin
                cmd.rd     = 1'b1;
                state_next = S_EVAL;
            end
            S_EVAL: begin
                cmd.eval   = 1'b1;
                state_next = S_PLAN;
            end
            S_PLAN: begin
                cmd.plan   = 1'b1;
                step_next  = '0;
                state_next = S_DIV;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 4'd1;
                if (step_reg == 4'(DIV_STEPS - 1)) begin
                    state_next = S_WRITE;
                end
            end
            S_WRITE: begin
                cmd.wr     = 1'b1;
                state_next = S_OUT;
            end
            S_OUT: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_CLR;
        endcase
    end
endmodule

>>> rtl/prbm_datapath.sv
// datapath: index reduction, slot store, match search, blend divider, output
module prbm_datapath #(
    parameter int SLOTS  = 3,
    parameter int PIXELS = 65536
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  prbm_pkg::cmd_t                cmd,
    output prbm_pkg::sts_t                sts,
    input  logic [55:0]                   s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [7:0]                    m_tdata,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [prbm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [prbm_pkg::CFG_DATA_W-1:0] cfg_data
);
    import prbm_pkg::*;

    localparam int AW    = (PIXELS > 1) ? $clog2(PIXELS) : 1;
    localparam int ROW_W = SLOTS * SLOT_W;
    localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int SUM_W = WW + 3;
    localparam int PL    = (PIXELS > 1) ? $clog2(PIXELS) : 0;
    localparam int RS    = IDX_W + PL;
    localparam int RMW   = IDX_W + 2;
    localparam int QPW   = IDX_W + RMW;
    localparam logic [RMW-1:0] RM = (PIXELS >= (1 << IDX_W)) ? RMW'(0)
        : RMW'(((64'd1 << RS) + 64'(PIXELS) - 64'd1) / 64'(PIXELS));
    localparam logic [IDX_W-1:0] PIX_K = IDX_W'(PIXELS);

    logic [THR_W-1:0]  thr_reg;
    logic [WW-1:0]     limit_reg;
    logic [IDX_W-1:0]  rem_reg;
    logic [IDX_W-1:0]  quot_reg;
    logic [CW-1:0]     px_reg;
    logic [RND_W-1:0]  rnd_reg;
    logic [AW:0]       clr_cnt_reg;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [DIST_W-1:0] dist_reg [SLOTS];
    act_t              act_reg, act_next;
    logic [SW-1:0]     sel_reg, sel_next;
    logic [WW-1:0]     w_reg, w_next;
    logic [WW-1:0]     minw_reg, minw_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [NUM_W-1:0]  num_reg [3];
    logic [DIV_REM_W-1:0] drem_reg [3];
    logic              repl_reg;
    logic [OUT_W-1:0]  out_reg;
    logic              out_valid_reg;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [ROW_W-1:0]  ram_wdata, ram_rdata;
    logic [AW-1:0]     row_addr;
    logic [QPW-1:0]    qprod;
    logic [2*IDX_W-1:0] qmul;

    assign cfg_ready = 1'b1;
    assign row_addr  = AW'(rem_reg);
    assign qprod     = QPW'(s_tdata[IDX_W-1:0]) * QPW'(RM);
    assign qmul      = (2*IDX_W)'(quot_reg) * (2*IDX_W)'(PIX_K);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg   <= THRESHOLD_RST;
            limit_reg <= LIMIT_RST;
        end else if (cfg_valid) begin
            if (cfg_index == CFG_THRESHOLD) begin
                thr_reg <= cfg_data;
            end else if (cfg_index == CFG_LIMIT) begin
                limit_reg <= cfg_data[WW-1:0];
            end
        end
    end

    // clearing pass counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else if (cmd.clr) begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end
    assign sts.clr_done = (clr_cnt_reg == (AW+1)'(PIXELS));

    // index reduction by reciprocal multiplication
    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            rem_reg  <= s_tdata[IDX_W-1:0];
            quot_reg <= IDX_W'(qprod >> RS);
            px_reg   <= s_tdata[IDX_W +: CW];
            rnd_reg  <= s_tdata[IDX_W+CW +: RND_W];
        end else if (cmd.mod_step) begin
            rem_reg <= rem_reg - qmul[IDX_W-1:0];
        end
    end

    assign ram_we    = cmd.clr | cmd.wr;
    assign ram_waddr = cmd.clr ? clr_cnt_reg[AW-1:0] : row_addr;
    assign ram_wdata = cmd.clr ? '0 : row_next;

    prbm_ram #(.WIDTH(ROW_W), .DEPTH(PIXELS)) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.rd),
        .raddr (row_addr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (cmd.eval) begin
            row_reg <= ram_rdata;
            for (int s = 0; s < SLOTS; s++) begin
                dist_reg[s] <= manhattan(px_reg, ram_rdata[s*SLOT_W +: CW]);
            end
        end else if (cmd.wr) begin
            row_reg <= row_next;
        end
    end

    // slot selection
    always_comb begin
        logic hit_f, emp_f;
        logic [SW-1:0] emp_k, min_k;
        logic [WW-1:0] wk;
        hit_f     = 1'b0;
        emp_f     = 1'b0;
        emp_k     = '0;
        min_k     = '0;
        sel_next  = '0;
        w_next    = '0;
        minw_next = row_reg[CW +: WW];
        sum_next  = '0;
        for (int s = 0; s < SLOTS; s++) begin
            wk = row_reg[s*SLOT_W+CW +: WW];
            sum_next = sum_next + SUM_W'(wk);
            if (!hit_f && wk != '0 && dist_reg[s] < thr_reg) begin
                hit_f    = 1'b1;
                sel_next = SW'(s);
                w_next   = wk;
            end
            if (!emp_f && wk == '0) begin
                emp_f = 1'b1;
                emp_k = SW'(s);
            end
            if (wk < minw_next) begin
                minw_next = wk;
                min_k     = SW'(s);
            end
        end
        priority if (hit_f) begin
            act_next = ACT_HIT;
        end else if (emp_f) begin
            act_next = ACT_INS;
            sel_next = emp_k;
        end else begin
            act_next = ACT_REPL;
            sel_next = min_k;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            act_reg <= ACT_NONE;
        end else if (cmd.plan) begin
            act_reg <= act_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.plan) begin
            sel_reg  <= sel_next;
            w_reg    <= w_next;
            minw_reg <= minw_next;
            sum_reg  <= sum_next;
            for (int c = 0; c < 3; c++) begin
                num_reg[c]  <= NUM_W'((w_next - 1'b1)
                               * row_reg[int'(sel_next)*SLOT_W + c*8 +: 8])
                               + NUM_W'(px_reg[c*8 +: 8]);
                drem_reg[c] <= '0;
            end
        end else if (cmd.div_step) begin
            repl_reg <= (26'(rnd_reg) * 26'(sum_reg))
                      < ((26'(minw_reg) << 16) - 26'(minw_reg));
            for (int c = 0; c < 3; c++) begin
                if ({drem_reg[c], num_reg[c][NUM_W-1]} >= (DIV_REM_W+1)'(w_reg)) begin
                    drem_reg[c] <= DIV_REM_W'({drem_reg[c], num_reg[c][NUM_W-1]}
                                   - (DIV_REM_W+1)'(w_reg));
                    num_reg[c]  <= {num_reg[c][NUM_W-2:0], 1'b1};
                end else begin
                    drem_reg[c] <= DIV_REM_W'({drem_reg[c], num_reg[c][NUM_W-1]});
                    num_reg[c]  <= {num_reg[c][NUM_W-2:0], 1'b0};
                end
            end
        end
    end

    // updated row
    always_comb begin
        logic [CW-1:0] blend;
        logic [WW-1:0] w_inc;
        blend = {num_reg[2][7:0], num_reg[1][7:0], num_reg[0][7:0]};
        w_inc = (w_reg < limit_reg) ? w_reg + 1'b1 : w_reg;
        row_next = row_reg;
        unique case (act_reg)
            ACT_HIT:  row_next[int'(sel_reg)*SLOT_W +: SLOT_W] = {w_inc, blend};
            ACT_INS:  row_next[int'(sel_reg)*SLOT_W +: SLOT_W] = {WW'(1), px_reg};
            ACT_REPL: begin
                if (repl_reg) begin
                    row_next[int'(sel_reg)*SLOT_W +: SLOT_W] = {WW'(1), px_reg};
                end
            end
            ACT_NONE: row_next = row_reg;
        endcase
    end

    // heaviest slot and difference
    logic [CW-1:0]     best_c;
    logic [DIST_W-1:0] best_d;
    logic [19:0]       best_p;
    always_comb begin
        logic [WW-1:0] bw;
        bw     = row_reg[CW +: WW];
        best_c = row_reg[CW-1:0];
        for (int s = 1; s < SLOTS; s++) begin
            if (row_reg[s*SLOT_W+CW +: WW] > bw) begin
                bw     = row_reg[s*SLOT_W+CW +: WW];
                best_c = row_reg[s*SLOT_W +: CW];
            end
        end
        best_d = manhattan(px_reg, best_c);
        best_p = 20'(best_d) * 20'(RECIP3);
    end

    assign sts.out_free = ~out_valid_reg | m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_reg <= best_p[RECIP3_SH +: OUT_W];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;
endmodule

>>> rtl/pixel_reservoir_background_model.sv
// top level: per-pixel multi-slot background model with foreground difference
// one pixel at a time: a new input transaction is taken only after the last result is loaded for output
// per pixel: index reduction, one store row read, slot planning, the bit-serial blend divider
// (14 steps), one store row write and the output load, which waits while the output is stalled by m_tready
// reset: a clearing pass zeroes all PIXELS rows of the slot store, s_tready low
module pixel_reservoir_background_model #(
    parameter int SLOTS  = 3,
    parameter int PIXELS = 65536
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // pixel_index, pixel_color, random_draw
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // foreground_difference
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [prbm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [prbm_pkg::CFG_DATA_W-1:0] cfg_data
);
    import prbm_pkg::*;

    cmd_t cmd;
    sts_t sts;

    prbm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    prbm_datapath #(.SLOTS(SLOTS), .PIXELS(PIXELS)) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );
endmodule

>>> rtl/prbm_checker.sv
// port-level checker for the background model, bound to the top level
`include "assert_macros.svh"
module prbm_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);
    `PRBM_ASSERT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid)
    `PRBM_ASSERT(a_out_stable, aclk, aresetn, m_tvalid && !m_tready |=> $stable(m_tdata))
    `PRBM_ASSERT(a_one_at_a_time, aclk, aresetn, s_tvalid && s_tready |=> !s_tready)
    `PRBM_ASSERT_ALWAYS(a_reset_quiet, aclk, !aresetn |=> !m_tvalid && !s_tready)
endmodule

bind pixel_reservoir_background_model prbm_checker u_prbm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
